// File: design/tbw_pkg.sv
package tbw_pkg;

   // Command codes carried on the request channel
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_BEEP = 2'd1;
   localparam logic [1:0] CMD_KICK = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_S  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WDOG_LIMIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WDOG_ENABLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EVENT_AGE_MAX = 3'd4;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [7:0]  TICK_PERIOD_RST   = 8'd10;
   localparam logic [7:0]  TICKS_PER_S_RST   = 8'd100;
   localparam logic [15:0] WDOG_LIMIT_RST    = 16'd1200;
   localparam logic        WDOG_ENABLE_RST   = 1'b1;
   localparam logic [31:0] EVENT_AGE_MAX_RST = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0]  tick_period_ms;
      logic [7:0]  ticks_per_second;
      logic [15:0] watchdog_limit_s;
      logic        watchdog_enable;
      logic [31:0] event_age_max_s;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  cmd;
      logic [15:0] beep_duration_ms;
      logic        event_seen;
   } step_type;

   typedef struct packed {
      logic [15:0] millis_now;
      logic [15:0] seconds_now;
      logic [31:0] uptime_s;
      logic [31:0] event_age_s;
      logic        buzzer_active;
      logic        reset_request;
   } result_type;

endpackage

// File: design/tick_timebase_with_soft_watchdog_unit.sv
// Channel  Handshake              Payload
// req      req_valid / req_stall  cmd, beep_duration_ms, event_seen
// rsp      rsp_valid / rsp_stall  millis_now, seconds_now, uptime_s, event_age_s,
//                                 buzzer_active, reset_request
// csr      csr_valid / csr_ready  csr_index, csr_data
//
// One request word is taken every clock cycle unless req_stall is high; each word
// gives one response word, carried through the input register and then the state
// update that loads the result register.
// Reset (synchronous, active high) clears all counters and the beep, and loads
// the configuration registers with their defaults.
// A response stall holds a valid result register; the input register then holds
// and req_stall rises only while it carries a word that cannot move on.
module tick_timebase_with_soft_watchdog_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic [15:0]                       req_beep_duration_ms,
   input  logic                              req_event_seen,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_millis_now,
   output logic [15:0]                       rsp_seconds_now,
   output logic [31:0]                       rsp_uptime_s,
   output logic [31:0]                       rsp_event_age_s,
   output logic                              rsp_buzzer_active,
   output logic                              rsp_reset_request,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tbw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tbw_pkg::CSR_DATA_W-1:0]    csr_data
);

   tbw_pkg::cfg_type    cfg;
   tbw_pkg::step_type   step_ff;
   tbw_pkg::result_type result;
   logic                take;

   // Registers accept a write in any cycle; writes must arrive only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   tbw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Hold the input word while the core cannot take it.
   assign req_stall = step_ff.valid && !take;

   // Valid is reset; the payload needs no reset and loads with each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else if (!req_stall) begin
         step_ff.valid <= req_valid;
      end
      if (req_valid && !req_stall) begin
         step_ff.cmd              <= req_cmd;
         step_ff.beep_duration_ms <= req_beep_duration_ms;
         step_ff.event_seen       <= req_event_seen;
      end
   end

   tbw_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step_ff),
      .take      (take),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .result    (result)
   );

   assign rsp_millis_now    = result.millis_now;
   assign rsp_seconds_now   = result.seconds_now;
   assign rsp_uptime_s      = result.uptime_s;
   assign rsp_event_age_s   = result.event_age_s;
   assign rsp_buzzer_active = result.buzzer_active;
   assign rsp_reset_request = result.reset_request;

endmodule

// File: design/tbw_csr.sv
module tbw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [tbw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tbw_pkg::CSR_DATA_W-1:0]      csr_data,
   output tbw_pkg::cfg_type                    cfg
);

   tbw_pkg::cfg_type cfg_ff;
   tbw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tbw_pkg::CSR_TICK_PERIOD:   cfg_in.tick_period_ms   = csr_data[7:0];
            tbw_pkg::CSR_TICKS_PER_S:   cfg_in.ticks_per_second = csr_data[7:0];
            tbw_pkg::CSR_WDOG_LIMIT:    cfg_in.watchdog_limit_s = csr_data[15:0];
            tbw_pkg::CSR_WDOG_ENABLE:   cfg_in.watchdog_enable  = csr_data[0];
            tbw_pkg::CSR_EVENT_AGE_MAX: cfg_in.event_age_max_s  = csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period_ms   <= tbw_pkg::TICK_PERIOD_RST;
         cfg_ff.ticks_per_second <= tbw_pkg::TICKS_PER_S_RST;
         cfg_ff.watchdog_limit_s <= tbw_pkg::WDOG_LIMIT_RST;
         cfg_ff.watchdog_enable  <= tbw_pkg::WDOG_ENABLE_RST;
         cfg_ff.event_age_max_s  <= tbw_pkg::EVENT_AGE_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/tbw_core.sv
module tbw_core (
   input  logic                 clock,
   input  logic                 reset,
   input  tbw_pkg::cfg_type     cfg,
   input  tbw_pkg::step_type    step,
   output logic                 take,
   output logic                 out_valid,
   input  logic                 out_stall,
   output tbw_pkg::result_type  result
);

   logic [7:0]  divider_ff,   divider_in;
   logic [15:0] millis_ff,    millis_in;
   logic [15:0] seconds_ff,   seconds_in;
   logic [31:0] uptime_ff,    uptime_in;
   logic [31:0] age_ff,       age_in;
   logic [15:0] wdog_ff,      wdog_in;
   logic        beep_on_ff,   beep_on_in;
   logic [15:0] beep_left_ff, beep_left_in;
   logic        out_valid_ff;
   tbw_pkg::result_type result_ff, result_in;

   logic [7:0]  divider_inc;
   logic        second_done;
   logic        request;
   logic [15:0] period_ext;

   assign take = step.valid && (!out_valid_ff || !out_stall);

   assign period_ext  = {8'd0, cfg.tick_period_ms};
   assign divider_inc = divider_ff + 8'd1;
   assign second_done = divider_inc >= cfg.ticks_per_second;

   always_comb begin
      divider_in   = divider_ff;
      millis_in    = millis_ff;
      seconds_in   = seconds_ff;
      uptime_in    = uptime_ff;
      age_in       = age_ff;
      wdog_in      = wdog_ff;
      beep_on_in   = beep_on_ff;
      beep_left_in = beep_left_ff;
      request      = 1'b0;
      case (step.cmd)
         tbw_pkg::CMD_TICK: begin
            if (beep_on_ff) begin
               if (beep_left_ff >= period_ext) begin
                  beep_left_in = beep_left_ff - period_ext;
               end else begin
                  beep_left_in = 16'd0;
                  beep_on_in   = 1'b0;
               end
            end
            millis_in = millis_ff + period_ext;
            if (second_done) begin
               divider_in = 8'd0;
               seconds_in = seconds_ff + 16'd1;
               uptime_in  = uptime_ff + 32'd1;
               wdog_in    = wdog_ff + 16'd1;
               request    = cfg.watchdog_enable && (wdog_in > cfg.watchdog_limit_s);
               if (step.event_seen && (age_ff < cfg.event_age_max_s)) begin
                  age_in = age_ff + 32'd1;
               end
            end else begin
               divider_in = divider_inc;
            end
         end
         tbw_pkg::CMD_BEEP: begin
            beep_on_in   = 1'b1;
            beep_left_in = step.beep_duration_ms;
         end
         tbw_pkg::CMD_KICK: begin
            wdog_in = 16'd0;
         end
         default: ;
      endcase
   end

   always_comb begin
      result_in.millis_now    = millis_in;
      result_in.seconds_now   = seconds_in;
      result_in.uptime_s      = uptime_in;
      result_in.event_age_s   = age_in;
      result_in.buzzer_active = beep_on_in;
      result_in.reset_request = request;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff   <= 8'd0;
         millis_ff    <= 16'd0;
         seconds_ff   <= 16'd0;
         uptime_ff    <= 32'd0;
         age_ff       <= 32'd0;
         wdog_ff      <= 16'd0;
         beep_on_ff   <= 1'b0;
         beep_left_ff <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            divider_ff   <= divider_in;
            millis_ff    <= millis_in;
            seconds_ff   <= seconds_in;
            uptime_ff    <= uptime_in;
            age_ff       <= age_in;
            wdog_ff      <= wdog_in;
            beep_on_ff   <= beep_on_in;
            beep_left_ff <= beep_left_in;
            out_valid_ff <= 1'b1;
         end else if (!out_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

endmodule
